FILE: src/apov_pkg.sv
// Package for the atom pair overlap volume pipeline.
// Holds widths, constants, type codes and the side-band record that travels
// with each pair. No dependencies.
package apov_pkg;

  // Bits of the Q.16 distance root and of the volume quotient
  localparam int SQRT_BITS = 20;
  localparam int QUO_BITS  = 36;
  localparam int REM_W     = 42;
  localparam int DIV_W     = 56;

  // pi/12 in Q.24, volume ceiling, search distance after reset
  localparam logic [22:0] PI12_Q24  = 23'd4392265;
  localparam logic [23:0] VOL_MAX   = 24'hFFFFFF;
  localparam logic [11:0] SD_RESET  = 12'd1178;

  // Hydrogen-bond type codes
  localparam logic [2:0] HB_ACC      = 3'd2;
  localparam logic [2:0] HB_BOTH     = 3'd3;
  localparam logic [2:0] HB_DONOR_H  = 3'd4;

  // Per-pair record carried down the pipeline
  typedef struct packed {
    logic [15:0]        tag;
    logic [12:0]        rsum;
    logic signed [12:0] rdiff;
    logic               hbc;
    logic               hoc;
    logic               zero;
    logic [SQRT_BITS-1:0] dq;
    logic               fpos;
    logic               sat;
  } side_t;

endpackage

FILE: src/atom_pair_overlap_volume_top.sv
// Top level of the atom pair overlap volume pipeline.
// Depends on apov_pkg.
//
// Screens one central/neighbour atom pair per beat. A pair whose squared
// centre distance is below both the squared search distance and the squared
// radius sum yields one result beat with the tag, the Q4.8 distance, the Q16.8
// lens volume and the h-bond flags; other pairs yield nothing. One pair
// enters per cycle while the pipeline is not held, and passes through: three
// stages form the squared distance, a 20-stage digit-by-digit square root
// gives the distance, four stages form the lens terms, a 36-stage restoring
// divider divides by the distance, and two stages scale by pi/12. The whole
// pipeline holds only while a finished result waits at the output and is not
// taken. Write the search distance only while the pipeline is empty.
module atom_pair_overlap_volume_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wen,
  input  logic [11:0]  cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pair_tag, central_x/y/z, neighbour_x/y/z, central_radius,
  // neighbour_radius, central_hb_type, neighbour_hb_type
  input  logic [167:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_tag, pair_distance, overlap_volume, hbond_candidate,
  // hydrogen_on_central, zero_distance
  output logic [55:0]  m_axis_tdata
);

  localparam int SB = apov_pkg::SQRT_BITS;
  localparam int QB = apov_pkg::QUO_BITS;
  localparam int RW = apov_pkg::REM_W;
  localparam int DW = apov_pkg::DIV_W;

  logic        en;
  logic [11:0] search_distance;

  // Search distance register
  always_ff @(posedge clk) begin
    if (rst) search_distance <= apov_pkg::SD_RESET;
    else if (cfg_wen) search_distance <= cfg_wdata;
  end

  // Pipeline moves unless the output holds an untaken result
  logic o_valid;
  assign en            = !o_valid || m_axis_tready;
  assign s_axis_tready = en;

  // Unpack input beat
  logic [19:0] cx, cy, cz, nx, ny, nz;
  logic [11:0] rc, rn;
  logic [2:0]  tc, tn;
  assign cx = s_axis_tdata[35:16];
  assign cy = s_axis_tdata[55:36];
  assign cz = s_axis_tdata[75:56];
  assign nx = s_axis_tdata[95:76];
  assign ny = s_axis_tdata[115:96];
  assign nz = s_axis_tdata[135:116];
  assign rc = s_axis_tdata[147:136];
  assign rn = s_axis_tdata[159:148];
  assign tc = s_axis_tdata[162:160];
  assign tn = s_axis_tdata[165:163];

  // Stage 1: coordinate differences and pair record
  logic                v1;
  logic signed [20:0]  dx1, dy1, dz1;
  apov_pkg::side_t     sd1, sd1_next;
  always_comb begin
    sd1_next       = '0;
    sd1_next.tag   = s_axis_tdata[15:0];
    sd1_next.rsum  = {1'b0, rc} + {1'b0, rn};
    sd1_next.rdiff = $signed({1'b0, rc}) - $signed({1'b0, rn});
    sd1_next.hoc   = (tc == apov_pkg::HB_DONOR_H) &&
                     (tn == apov_pkg::HB_ACC || tn == apov_pkg::HB_BOTH);
    sd1_next.hbc   = sd1_next.hoc || ((tn == apov_pkg::HB_DONOR_H) &&
                     (tc == apov_pkg::HB_ACC || tc == apov_pkg::HB_BOTH));
  end
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_axis_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dx1 <= $signed({nx[19], nx}) - $signed({cx[19], cx});
      dy1 <= $signed({ny[19], ny}) - $signed({cy[19], cy});
      dz1 <= $signed({nz[19], nz}) - $signed({cz[19], cz});
      sd1 <= sd1_next;
    end
  end

  // Stage 2: squares at full width
  logic               v2;
  logic [41:0]        qx2, qy2, qz2;
  logic signed [41:0] sqx, sqy, sqz;
  apov_pkg::side_t    sd2;
  assign sqx = dx1 * dx1;
  assign sqy = dy1 * dy1;
  assign sqz = dz1 * dz1;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      qx2 <= $unsigned(sqx);
      qy2 <= $unsigned(sqy);
      qz2 <= $unsigned(sqz);
      sd2 <= sd1;
    end
  end

  // Stage 3: squared distance and range tests; drop pairs that fail
  logic            v3;
  logic [23:0]     ds3;
  apov_pkg::side_t sd3, sd3_next;
  logic [43:0]     ds_full;
  logic [23:0]     sd_sq;
  logic [25:0]     rs_sq;
  assign ds_full = {2'b0, qx2} + {2'b0, qy2} + {2'b0, qz2};
  assign sd_sq   = search_distance * search_distance;
  assign rs_sq   = sd2.rsum * sd2.rsum;
  always_comb begin
    sd3_next      = sd2;
    sd3_next.zero = (ds_full == '0);
  end
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2 && (ds_full < {20'b0, sd_sq}) && (ds_full < {18'b0, rs_sq});
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ds3 <= ds_full[23:0];
      sd3 <= sd3_next;
    end
  end

  // Square root of ds * 2^16, one root bit per stage
  logic [RW-1:0]   sq_rem  [0:SB-1];
  logic [SB-1:0]   sq_root [0:SB-1];
  logic            sq_v    [0:SB-1];
  apov_pkg::side_t sq_sd   [0:SB-1];

  for (genvar j = 0; j < SB; j++) begin : g_sqrt
    localparam int K = SB - 1 - j;
    logic [RW-1:0]   rem_in, test;
    logic [SB-1:0]   root_in;
    logic            v_in;
    apov_pkg::side_t sd_in;
    if (j == 0) begin : g_first
      assign rem_in  = {2'b0, ds3, 16'b0};
      assign root_in = '0;
      assign v_in    = v3;
      assign sd_in   = sd3;
    end else begin : g_next
      assign rem_in  = sq_rem[j-1];
      assign root_in = sq_root[j-1];
      assign v_in    = sq_v[j-1];
      assign sd_in   = sq_sd[j-1];
    end
    assign test = ({{(RW-SB){1'b0}}, root_in} << (K + 1)) + ({{(RW-1){1'b0}}, 1'b1} << (2 * K));
    always_ff @(posedge clk) begin
      if (rst) sq_v[j] <= 1'b0;
      else if (en) sq_v[j] <= v_in;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_sd[j] <= sd_in;
        if (rem_in >= test) begin
          sq_rem[j]  <= rem_in - test;
          sq_root[j] <= root_in | (SB'(1) << K);
        end else begin
          sq_rem[j]  <= rem_in;
          sq_root[j] <= root_in;
        end
      end
    end
  end

  // Stage a: lens terms, first products
  logic            va;
  logic [20:0]     ta;
  logic [39:0]     dqdq_a;
  logic [32:0]     dqs_a;
  logic [23:0]     d2_a;
  apov_pkg::side_t sda, sda_next;
  logic [SB-1:0]   dq;
  logic signed [25:0] d2_full;
  assign dq      = sq_root[SB-1];
  assign d2_full = sq_sd[SB-1].rdiff * sq_sd[SB-1].rdiff;
  always_comb begin
    sda_next    = sq_sd[SB-1];
    sda_next.dq = dq;
  end
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (en) va <= sq_v[SB-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ta     <= {sq_sd[SB-1].rsum, 8'b0} - {1'b0, dq};
      dqdq_a <= dq * dq;
      dqs_a  <= dq * sq_sd[SB-1].rsum;
      d2_a   <= d2_full[23:0];
      sda    <= sda_next;
    end
  end

  // Stage b: square of the cap height term, sign and upper half of F
  logic            vb;
  logic [41:0]     ttb;
  logic [26:0]     fh_b;
  apov_pkg::side_t sdb, sdb_next;
  logic [42:0]     g_sum;
  logic [25:0]     h3;
  assign g_sum = {3'b0, dqdq_a} + {1'b0, dqs_a, 9'b0};
  assign h3    = {2'b0, d2_a} + {1'b0, d2_a, 1'b0};
  always_comb begin
    sdb_next      = sda;
    sdb_next.fpos = g_sum > {1'b0, h3, 16'b0};
  end
  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (en) vb <= va;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ttb  <= ta * ta;
      fh_b <= g_sum[42:16] - {1'b0, h3};
      sdb  <= sdb_next;
    end
  end

  // Stage c: numerator product
  logic            vc;
  logic [52:0]     pc;
  apov_pkg::side_t sdc;
  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else if (en) vc <= vb;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pc  <= ttb[41:16] * fh_b;
      sdc <= sdb;
    end
  end

  // Stage d: quotient overflow check
  logic            vd;
  logic [DW-1:0]   pd;
  apov_pkg::side_t sdd, sdd_next;
  always_comb begin
    sdd_next     = sdc;
    sdd_next.sat = {3'b0, pc} >= {sdc.dq, 36'b0};
  end
  always_ff @(posedge clk) begin
    if (rst) vd <= 1'b0;
    else if (en) vd <= vc;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pd  <= {3'b0, pc};
      sdd <= sdd_next;
    end
  end

  // Restoring division by the distance, one quotient bit per stage
  logic [DW-1:0]   dv_rem [0:QB-1];
  logic [QB-1:0]   dv_q   [0:QB-1];
  logic            dv_v   [0:QB-1];
  apov_pkg::side_t dv_sd  [0:QB-1];

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int K = QB - 1 - j;
    logic [DW-1:0]   rem_in, test;
    logic [QB-1:0]   q_in;
    logic            v_in;
    apov_pkg::side_t sd_in;
    if (j == 0) begin : g_first
      assign rem_in = pd;
      assign q_in   = '0;
      assign v_in   = vd;
      assign sd_in  = sdd;
    end else begin : g_next
      assign rem_in = dv_rem[j-1];
      assign q_in   = dv_q[j-1];
      assign v_in   = dv_v[j-1];
      assign sd_in  = dv_sd[j-1];
    end
    assign test = {{(DW-SB){1'b0}}, sd_in.dq} << K;
    always_ff @(posedge clk) begin
      if (rst) dv_v[j] <= 1'b0;
      else if (en) dv_v[j] <= v_in;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_sd[j] <= sd_in;
        if (rem_in >= test) begin
          dv_rem[j] <= rem_in - test;
          dv_q[j]   <= q_in | (QB'(1) << K);
        end else begin
          dv_rem[j] <= rem_in;
          dv_q[j]   <= q_in;
        end
      end
    end
  end

  // Stage m: scale by pi/12 in two halves
  logic            vm;
  logic [40:0]     ph_m, pl_m;
  apov_pkg::side_t sdm;
  always_ff @(posedge clk) begin
    if (rst) vm <= 1'b0;
    else if (en) vm <= dv_v[QB-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ph_m <= dv_q[QB-1][35:18] * apov_pkg::PI12_Q24;
      pl_m <= dv_q[QB-1][17:0] * apov_pkg::PI12_Q24;
      sdm  <= dv_sd[QB-1];
    end
  end

  // Output stage: round, saturate, pack
  logic [59:0] vsum;
  logic [27:0] vraw;
  logic [23:0] vol;
  logic [55:0] o_data;
  assign vsum = {1'b0, ph_m, 18'b0} + {19'b0, pl_m} + 60'h0_0000_0000_8000_0000;
  assign vraw = vsum[59:32];
  always_comb begin
    if (sdm.zero || (sdm.fpos && sdm.sat)) vol = apov_pkg::VOL_MAX;
    else if (!sdm.fpos) vol = '0;
    else if (vraw > {4'b0, apov_pkg::VOL_MAX}) vol = apov_pkg::VOL_MAX;
    else vol = vraw[23:0];
  end
  always_ff @(posedge clk) begin
    if (rst) o_valid <= 1'b0;
    else if (en) o_valid <= vm;
  end
  always_ff @(posedge clk) begin
    if (en) o_data <= {1'b0, sdm.zero, sdm.hoc, sdm.hbc, vol, sdm.dq[19:8], sdm.tag};
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = o_data;

endmodule

FILE: tb/tb.sv
// Testbench for the atom pair overlap volume pipeline.
// Drives pair beats with random gaps, predicts results internally and
// checks every result beat; depends on apov_pkg and atom_pair_overlap_volume_top.
`timescale 1ns / 100ps

module tb;

  localparam int LATENCY   = 65;
  localparam int WD_LIMIT  = 20000;
  localparam int N_RANDOM  = 1850;

  typedef struct packed {
    logic [2:0]  tn;
    logic [2:0]  tc;
    logic [11:0] rn;
    logic [11:0] rc;
    logic signed [19:0] nz;
    logic signed [19:0] ny;
    logic signed [19:0] nx;
    logic signed [19:0] cz;
    logic signed [19:0] cy;
    logic signed [19:0] cx;
    logic [15:0] tag;
  } pair_t;

  typedef struct packed {
    logic        zero;
    logic        hoc;
    logic        hbc;
    logic [23:0] vol;
    logic [11:0] pdist;
    logic [15:0] tag;
  } contact_t;

  logic clk, rst;
  logic cfg_wen;
  logic [11:0] cfg_wdata;
  logic s_axis_tvalid, s_axis_tready;
  logic [167:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [55:0] m_axis_tdata;

  pair_t    pending_pairs[$];
  contact_t expected_contacts[$];
  logic [11:0] search_dist;
  logic [11:0] sd_list [5];
  int  errors = 0;
  bit  stall_long = 0;
  bit  in_fire = 0;
  int  hold_cycles = 0;
  int  idle_count = 0;

  atom_pair_overlap_volume_top DUT (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Screen one pair; queue the contact if it overlaps within the search range
  task automatic predict_contact(input pair_t p);
    longint dx, dy, dz, dlt, f;
    logic [63:0] ds, s, dq, t, a, pr, qv, v;
    logic hc, hn;
    contact_t c;
    dx = longint'(p.nx) - longint'(p.cx);
    dy = longint'(p.ny) - longint'(p.cy);
    dz = longint'(p.nz) - longint'(p.cz);
    ds = dx * dx + dy * dy + dz * dz;
    s = 64'(p.rc) + 64'(p.rn);
    if (!(ds < 64'(search_dist) * 64'(search_dist))) return;
    if (!(ds < s * s)) return;
    hc = (p.tc == apov_pkg::HB_DONOR_H) &&
         (p.tn == apov_pkg::HB_ACC || p.tn == apov_pkg::HB_BOTH);
    hn = (p.tc == apov_pkg::HB_ACC || p.tc == apov_pkg::HB_BOTH) &&
         (p.tn == apov_pkg::HB_DONOR_H);
    c.zero = 0;
    if (ds == 0) begin
      v = 64'(apov_pkg::VOL_MAX);
      c.zero = 1;
    end else begin
      dq = int_sqrt(ds << 16);
      t = (s << 8) - dq;
      a = (t * t) >> 16;
      dlt = longint'(p.rc) - longint'(p.rn);
      f = longint'(dq * dq) + longint'(2 * dq * (s << 8)) - ((3 * dlt * dlt) << 16);
      if (f <= 0) begin
        v = 0;
      end else begin
        pr = a * (64'(f) >> 16);
        qv = pr / dq;
        if (qv >= (64'd1 << 36)) begin
          v = 64'(apov_pkg::VOL_MAX);
        end else begin
          v = (qv * 64'(apov_pkg::PI12_Q24) + (64'd1 << 31)) >> 32;
          if (v > 64'(apov_pkg::VOL_MAX)) v = 64'(apov_pkg::VOL_MAX);
        end
      end
    end
    c.tag = p.tag;
    c.pdist = 12'(int_sqrt(ds));
    c.vol = v[23:0];
    c.hbc = hc || hn;
    c.hoc = hc;
    expected_contacts.insert(expected_contacts.size(), c);
  endtask

  // Drive: bursts of beats separated by random gaps, changed on the falling edge
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && !in_fire) begin
        // hold the offered beat
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 0;
      end else if (pending_pairs.size() > 0) begin
        s_axis_tvalid <= 1;
        s_axis_tdata <= {2'b0, pending_pairs.pop_front()};
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 0;
      end
    end
  end

  // Receiver stall pattern, with a long hold-off on request
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= (stall_phase + 1) % 97;
    if (stall_long) begin
      m_axis_tready <= 0;
    end else if (stall_phase < 30) begin
      m_axis_tready <= 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Accept at the input edge: note the beat and predict its result
  always @(posedge clk) begin
    in_fire <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready)
      predict_contact(pair_t'(s_axis_tdata[165:0]));
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    contact_t got, exp_c;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = contact_t'(m_axis_tdata[54:0]);
      if (expected_contacts.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual %h", $time, got);
      end else begin
        exp_c = expected_contacts.pop_front();
        if (got.tag !== exp_c.tag)
          $display("%0t: tag expected %h actual %h", $time, exp_c.tag, got.tag);
        if (got.pdist !== exp_c.pdist)
          $display("%0t: distance expected %0d actual %0d", $time, exp_c.pdist, got.pdist);
        if (got.vol !== exp_c.vol)
          $display("%0t: volume expected %0d actual %0d", $time, exp_c.vol, got.vol);
        if (got.hbc !== exp_c.hbc)
          $display("%0t: hbond expected %b actual %b", $time, exp_c.hbc, got.hbc);
        if (got.hoc !== exp_c.hoc)
          $display("%0t: h on central expected %b actual %b", $time, exp_c.hoc, got.hoc);
        if (got.zero !== exp_c.zero)
          $display("%0t: zero expected %b actual %b", $time, exp_c.zero, got.zero);
        if (got !== exp_c) errors++;
      end
    end
  end

  // Watchdog: count cycles with no beat on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || stall_long)
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= WD_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [19:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 20'(20'h80000 + $urandom_range(0, 3));
      1: return 20'(20'h7FFFF - $urandom_range(0, 3));
      default: return 20'($urandom);
    endcase
  endfunction

  // Pair with a neighbour near the central atom; mostly overlapping
  function automatic pair_t near_pair(input int spread);
    pair_t p;
    p.tag = 16'($urandom);
    p.cx = 20'($urandom); p.cy = 20'($urandom); p.cz = 20'($urandom);
    p.nx = 20'(p.cx + $signed($urandom_range(0, 2 * spread)) - spread);
    p.ny = 20'(p.cy + $signed($urandom_range(0, 2 * spread)) - spread);
    p.nz = 20'(p.cz + $signed($urandom_range(0, 2 * spread)) - spread);
    p.rc = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(200, 700));
    p.rn = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(200, 700));
    p.tc = 3'($urandom_range(0, 7));
    p.tn = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 4) == 0) p.nx = p.cx;
    if ($urandom_range(0, 30) == 0) begin
      p.nx = p.cx; p.ny = p.cy; p.nz = p.cz;
    end
    return p;
  endfunction

  function automatic pair_t noise_pair();
    pair_t p;
    p = 166'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    p.cx = rand_coord(); p.nx = rand_coord();
    return p;
  endfunction

  task automatic drain();
    while (pending_pairs.size() > 0 || s_axis_tvalid || expected_contacts.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_search(input logic [11:0] d);
    @(negedge clk);
    cfg_wen <= 1;
    cfg_wdata <= d;
    search_dist = d;
    @(negedge clk);
    cfg_wen <= 0;
  endtask

  pair_t p;
  initial begin
    rst = 1; cfg_wen = 0; cfg_wdata = 0;
    s_axis_tvalid = 0; s_axis_tdata = 0; m_axis_tready = 0;
    search_dist = apov_pkg::SD_RESET;
    sd_list = '{12'd0, 12'd4095, 12'd300, 12'd1178, 12'd2000};
    repeat (3) @(posedge clk);
    @(negedge clk) rst = 0;

    // Directed: coincident centres, deep inside, zero radii, type codes
    p = '0; p.rc = 12'd400; p.rn = 12'd300;
    p.tc = apov_pkg::HB_DONOR_H; p.tn = apov_pkg::HB_ACC;
    pending_pairs.insert(pending_pairs.size(), p);
    p.nx = 20'sd100; p.tc = apov_pkg::HB_BOTH; p.tn = apov_pkg::HB_DONOR_H;
    pending_pairs.insert(pending_pairs.size(), p);
    p.rc = 12'd1000; p.rn = 12'd50; p.nx = 20'sd20; p.tn = apov_pkg::HB_BOTH;
    pending_pairs.insert(pending_pairs.size(), p);
    p.rc = 0; p.rn = 0; pending_pairs.insert(pending_pairs.size(), p);
    p.rc = 12'hFFF; p.rn = 12'hFFF; p.nx = 20'sd1000; p.tc = 3'd7; p.tn = 3'd5;
    pending_pairs.insert(pending_pairs.size(), p);
    p.tag = 16'hFFFF; p.cx = 20'h80000; p.nx = 20'h7FFFF;
    pending_pairs.insert(pending_pairs.size(), p);
    for (int i = 0; i < 16; i++) pending_pairs.insert(pending_pairs.size(), near_pair(600));
    drain();

    // Random phases across several search distances, extremes included
    for (int k = 0; k < 5; k++) begin
      write_search(sd_list[k]);
      for (int i = 0; i < N_RANDOM / 5; i++)
        pending_pairs.insert(pending_pairs.size(),
                             ($urandom_range(0, 9) == 0) ? noise_pair() : near_pair(1200));
      if (k == 1) begin
        // long receiver hold-off while the sender keeps offering beats
        repeat (40) @(posedge clk);
        @(negedge clk) stall_long = 1;
        hold_cycles = 0;
        while (hold_cycles < 300) begin
          @(posedge clk);
          hold_cycles++;
        end
        @(negedge clk) stall_long = 0;
      end
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
